>>> design/poc_pkg.sv
package poc_pkg;

  localparam int POC_POOL_MAX = 1024;
  localparam int POC_GEN_MAX  = 8;

  localparam int POINT_W     = 10;
  localparam int GEN_W       = 3;
  localparam int COUNT_W     = 11;
  localparam int SQUARE_W    = 21;
  localparam int POOL_LEN_W  = 11;
  localparam int GEN_COUNT_W = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [POOL_LEN_W-1:0]  POOL_LEN_RST  = 11'd1024;
  localparam logic [GEN_COUNT_W-1:0] GEN_COUNT_RST = 4'd8;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_LEN  = 1'b0,
    CFG_GEN_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_TAKE,
    ST_GREAD,
    ST_GVIS,
    ST_GCHK,
    ST_NODE_END,
    ST_SQUARE,
    ST_ACC,
    ST_FINISH
  } walk_state_e;

  typedef struct packed {
    logic               action;
    logic [GEN_W-1:0]   generator;
    logic [POINT_W-1:0] point;
    logic [POINT_W-1:0] image_point;
  } poc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  orbit_count;
    logic [SQUARE_W-1:0] square_total;
    logic                bad_image;
  } poc_out_t;

  typedef struct packed {
    logic [POOL_LEN_W-1:0]  pool_len;
    logic [GEN_COUNT_W-1:0] generator_count;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    poc_out_t data;
  } res_t;

endpackage

>>> design/poc_stream_if.sv
interface poc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/poc_ram.sv
module poc_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/poc_walker.sv
module poc_walker import poc_pkg::*; #(
  parameter int POOL_MAX = POC_POOL_MAX,
  parameter int GEN_MAX  = POC_GEN_MAX
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  poc_stream_if.sink    in_i,
  output res_t          res_o,
  input  logic          res_ready_i
);

  localparam int PW  = $clog2(POOL_MAX);
  localparam int CW  = $clog2(POOL_MAX + 1);
  localparam int GCW = $clog2(GEN_MAX + 1);
  localparam int TD  = GEN_MAX * POOL_MAX;
  localparam int TW  = $clog2(TD);

  walk_state_e state_q, state_d;

  logic [CW-1:0]       limit_q, limit_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       start_q, start_d;
  logic [CW-1:0]       depth_q, depth_d;
  logic [CW-1:0]       size_q, size_d;
  logic [GCW-1:0]      gens_q, gens_d;
  logic [GCW-1:0]      g_q, g_d;
  logic [PW-1:0]       taken_q, taken_d;
  logic [PW-1:0]       img_q, img_d;
  logic [COUNT_W-1:0]  tally_q, tally_d;
  logic [SQUARE_W-1:0] sum_q, sum_d;
  logic [SQUARE_W-1:0] sq_q, sq_d;
  logic                bad_q, bad_d;
  logic [2*CW-1:0]     size_sq;

  logic               tbl_we;
  logic [TW-1:0]      tbl_waddr, tbl_raddr;
  logic [POINT_W-1:0] tbl_wdata, tbl_rdata;
  logic               vis_we;
  logic [PW-1:0]      vis_waddr, vis_raddr;
  logic               vis_wdata, vis_rdata;
  logic               stk_we;
  logic [PW-1:0]      stk_waddr, stk_raddr;
  logic [PW-1:0]      stk_wdata, stk_rdata;

  logic          in_acc, compute_req, write_ok;
  logic [CW-1:0] cfg_limit;
  logic [GCW-1:0] cfg_gens;
  logic          img_bad, last_gen, last_start, last_idx;

  function automatic logic [TW-1:0] tbl_addr(input logic [TW-1:0] gen,
                                             input logic [TW-1:0] pt);
    return gen * TW'(POOL_MAX) + pt;
  endfunction

  assign in_acc      = in_i.valid && in_i.ready;
  assign compute_req = in_acc && (in_i.data.action == ACT_COMPUTE);
  assign write_ok    = (32'(in_i.data.generator) < 32'(GEN_MAX)) &&
                       (32'(in_i.data.point) < 32'(POOL_MAX));
  assign cfg_limit   = (32'(cfg_i.pool_len) > 32'(POOL_MAX)) ? CW'(POOL_MAX)
                                                             : CW'(cfg_i.pool_len);
  assign cfg_gens    = (32'(cfg_i.generator_count) > 32'(GEN_MAX)) ? GCW'(GEN_MAX)
                                                                   : GCW'(cfg_i.generator_count);
  assign img_bad     = 32'(tbl_rdata) >= 32'(limit_q);
  assign last_gen    = (g_q + GCW'(1)) == gens_q;
  assign last_start  = start_q == (limit_q - CW'(1));
  assign last_idx    = idx_q == (limit_q - CW'(1));
  assign size_sq     = size_q * size_q;

  poc_ram #(.DEPTH(TD), .WIDTH(POINT_W)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  poc_ram #(.DEPTH(POOL_MAX), .WIDTH(1)) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  poc_ram #(.DEPTH(POOL_MAX), .WIDTH(PW)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (compute_req) begin
          state_d = (cfg_limit == '0) ? ST_FINISH : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (last_idx) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!vis_rdata) begin
          state_d = ST_POP;
        end else if (last_start) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_POP: state_d = ST_TAKE;
      ST_TAKE: state_d = (gens_q == '0) ? ST_NODE_END : ST_GREAD;
      ST_GREAD: state_d = ST_GVIS;
      ST_GVIS: begin
        if (!img_bad) begin
          state_d = ST_GCHK;
        end else begin
          state_d = last_gen ? ST_NODE_END : ST_GREAD;
        end
      end
      ST_GCHK: state_d = last_gen ? ST_NODE_END : ST_GREAD;
      ST_NODE_END: state_d = (depth_q == '0) ? ST_SQUARE : ST_POP;
      ST_SQUARE: state_d = ST_ACC;
      ST_ACC: state_d = last_start ? ST_FINISH : ST_SCAN;
      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    res_o.valid = (state_q == ST_FINISH);
    res_o.data.orbit_count = tally_q;
    res_o.data.square_total = sum_q;
    res_o.data.bad_image = bad_q;
    tbl_we    = 1'b0;
    tbl_waddr = tbl_addr(TW'(in_i.data.generator), TW'(in_i.data.point));
    tbl_wdata = in_i.data.image_point;
    tbl_raddr = tbl_addr(TW'(g_q), TW'(taken_q));
    vis_we    = 1'b0;
    vis_waddr = PW'(start_q);
    vis_wdata = 1'b1;
    vis_raddr = PW'(start_q);
    stk_we    = 1'b0;
    stk_waddr = PW'(depth_q);
    stk_wdata = img_q;
    stk_raddr = PW'(depth_q - CW'(1));
    case (state_q)
      ST_IDLE: begin
        tbl_we = in_acc && (in_i.data.action == ACT_WRITE) && write_ok;
      end
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = PW'(idx_q);
        vis_wdata = 1'b0;
      end
      ST_SCAN_CHK: begin
        if (!vis_rdata) begin
          vis_we    = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = PW'(start_q);
        end
      end
      ST_GVIS: begin
        vis_raddr = PW'(tbl_rdata);
      end
      ST_GCHK: begin
        if (!vis_rdata) begin
          vis_we    = 1'b1;
          vis_waddr = img_q;
          stk_we    = 32'(depth_q) < 32'(POOL_MAX);
        end
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    limit_d = limit_q;
    gens_d  = gens_q;
    idx_d   = idx_q;
    start_d = start_q;
    depth_d = depth_q;
    size_d  = size_q;
    g_d     = g_q;
    taken_d = taken_q;
    img_d   = img_q;
    tally_d = tally_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    bad_d   = bad_q;
    case (state_q)
      ST_IDLE: begin
        if (compute_req) begin
          limit_d = cfg_limit;
          gens_d  = cfg_gens;
          idx_d   = '0;
          start_d = '0;
          depth_d = '0;
          tally_d = '0;
          sum_d   = '0;
          bad_d   = 1'b0;
        end
      end
      ST_CLEAR: idx_d = idx_q + CW'(1);
      ST_SCAN_CHK: begin
        if (!vis_rdata) begin
          tally_d = tally_q + COUNT_W'(1);
          depth_d = CW'(1);
          size_d  = '0;
        end else if (!last_start) begin
          start_d = start_q + CW'(1);
        end
      end
      ST_POP: begin
        depth_d = depth_q - CW'(1);
        size_d  = size_q + CW'(1);
      end
      ST_TAKE: begin
        taken_d = stk_rdata;
        g_d     = '0;
      end
      ST_GVIS: begin
        if (img_bad) begin
          bad_d = 1'b1;
          if (!last_gen) begin
            g_d = g_q + GCW'(1);
          end
        end else begin
          img_d = PW'(tbl_rdata);
        end
      end
      ST_GCHK: begin
        if (!vis_rdata && (32'(depth_q) < 32'(POOL_MAX))) begin
          depth_d = depth_q + CW'(1);
        end
        if (!last_gen) begin
          g_d = g_q + GCW'(1);
        end
      end
      ST_SQUARE: sq_d = SQUARE_W'(size_sq);
      ST_ACC: begin
        sum_d = sum_q + sq_q;
        if (!last_start) begin
          start_d = start_q + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      limit_q <= '0;
      gens_q  <= '0;
      idx_q   <= '0;
      start_q <= '0;
      depth_q <= '0;
      g_q     <= '0;
      tally_q <= '0;
      sum_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      gens_q  <= gens_d;
      idx_q   <= idx_d;
      start_q <= start_d;
      depth_q <= depth_d;
      g_q     <= g_d;
      tally_q <= tally_d;
      sum_q   <= sum_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    taken_q <= taken_d;
    img_q   <= img_d;
    sq_q    <= sq_d;
  end

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= 32'(POOL_MAX))
    else $error("walk stack depth beyond pool");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (depth_q != '0))
    else $error("pop from empty walk stack");

  a_img_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCHK) |-> (32'(img_q) < 32'(limit_q)))
    else $error("out of pool image reached visited check");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tally_q) <= (32'(start_q) + 32'd1))
    else $error("more orbits than start points");
`endif

endmodule

>>> design/permutation_orbit_counter.sv
// table write request: taken one per cycle while the walker is idle, no result
// compute request: the visited map is cleared, then each start point of the effective pool
//   P is scanned and each new orbit walked over the G generators, one table read and one
//   visited read per generator step; no new request is taken until the result is handed on
// the visited map is swept clear at the start of every compute with a nonempty pool
// reset: pool length 1024, generator count 8, walker idle, no result pending
module permutation_orbit_counter import poc_pkg::*; #(
  parameter int POOL_MAX = POC_POOL_MAX,
  parameter int GEN_MAX  = POC_GEN_MAX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  poc_stream_if.sink            in_i,
  poc_stream_if.source          out_o
);

  cfg_t     cfg_q, cfg_d;
  res_t     res;
  logic     res_ready;
  logic     out_valid_q, out_valid_d;
  poc_out_t out_data_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_LEN: cfg_d.pool_len = cfg_data_i[POOL_LEN_W-1:0];
        CFG_GEN_COUNT: cfg_d.generator_count = cfg_data_i[GEN_COUNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  poc_walker #(
    .POOL_MAX (POOL_MAX),
    .GEN_MAX  (GEN_MAX)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready   = !out_valid_q || out_o.ready;
  assign out_valid_d = (res.valid && res_ready) ? 1'b1
                     : (out_o.ready ? 1'b0 : out_valid_q);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_len        <= POOL_LEN_RST;
      cfg_q.generator_count <= GEN_COUNT_RST;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_data_q <= res.data;
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import poc_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1850;
  localparam int unsigned COMPUTE_TARGET = 40;
  localparam int unsigned CYCLE_LIMIT    = 1200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  poc_stream_if #(.payload_t(poc_in_t))  in_if ();
  poc_stream_if #(.payload_t(poc_out_t)) out_if ();

  permutation_orbit_counter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // predictor state
  logic [POINT_W-1:0] image_tbl [POC_GEN_MAX][POC_POOL_MAX];
  int unsigned        cfg_pool = POOL_LEN_RST;
  int unsigned        cfg_gens = GEN_COUNT_RST;
  poc_out_t           orbit_results_q[$];

  // stimulus state
  poc_in_t     request_q[$];
  bit          loaded [POC_GEN_MAX][POC_POOL_MAX];
  int unsigned items_sent    = 0;
  int unsigned computes_sent = 0;

  int unsigned send_wait  = 0;
  int unsigned send_quiet = 0;
  int unsigned recv_wait  = 0;
  int unsigned recv_quiet = 0;
  int unsigned recv_draw;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(20, 80);
    return $urandom_range(0, 17);
  endfunction

  function automatic poc_out_t predict_orbits();
    bit                 seen [POC_POOL_MAX];
    logic [POINT_W-1:0] dfs_stack [POC_POOL_MAX];
    logic [POINT_W-1:0] nxt;
    int unsigned        limit;
    int unsigned        gens;
    int unsigned        depth;
    int unsigned        node;
    int unsigned        orbit_size;
    poc_out_t           res;
    limit = (cfg_pool > POC_POOL_MAX) ? POC_POOL_MAX : cfg_pool;
    gens  = (cfg_gens > POC_GEN_MAX) ? POC_GEN_MAX : cfg_gens;
    seen  = '{default: 1'b0};
    res   = '0;
    for (int s = 0; s < limit; s++) begin
      if (seen[s]) continue;
      res.orbit_count = res.orbit_count + 1'b1;
      seen[s]      = 1'b1;
      dfs_stack[0] = POINT_W'(s);
      depth        = 1;
      orbit_size   = 0;
      while (depth > 0) begin
        depth--;
        node = dfs_stack[depth];
        orbit_size++;
        for (int g = 0; g < gens; g++) begin
          nxt = image_tbl[g][node];
          if (nxt >= limit) begin
            res.bad_image = 1'b1;
            continue;
          end
          if (seen[nxt]) continue;
          seen[nxt]        = 1'b1;
          dfs_stack[depth] = nxt;
          depth++;
        end
      end
      res.square_total = res.square_total + SQUARE_W'(orbit_size * orbit_size);
    end
    return res;
  endfunction

  function automatic void take_request(poc_in_t req);
    if (req.action == ACT_WRITE) begin
      image_tbl[req.generator][req.point] = req.image_point;
    end else begin
      orbit_results_q = {orbit_results_q, predict_orbits()};
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result(poc_out_t got);
    poc_out_t want;
    if (orbit_results_q.size() == 0) begin
      report_mismatch($sformatf("result with none outstanding: orbits %0d squares %0d bad %0d",
                                got.orbit_count, got.square_total, got.bad_image));
      return;
    end
    want = orbit_results_q.pop_front();
    if (got.orbit_count !== want.orbit_count)
      report_mismatch($sformatf("orbit_count got %0d expected %0d",
                                got.orbit_count, want.orbit_count));
    if (got.square_total !== want.square_total)
      report_mismatch($sformatf("square_total got %0d expected %0d",
                                got.square_total, want.square_total));
    if (got.bad_image !== want.bad_image)
      report_mismatch($sformatf("bad_image got %0d expected %0d",
                                got.bad_image, want.bad_image));
  endtask

  // request source
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_wait   <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_wait != 0) begin
        in_if.valid <= 1'b0;
        send_wait   <= send_wait - 1;
      end else if (request_q.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= request_q.pop_front();
        send_wait   <= draw_wait(send_quiet);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) take_request(in_if.data);
  end

  // result sink
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait    <= 0;
    end else if (out_if.valid && out_if.ready) begin
      check_result(out_if.data);
      recv_draw = draw_wait(recv_quiet);
      out_if.ready <= (recv_draw == 0);
      recv_wait    <= recv_draw;
    end else if (!out_if.ready) begin
      if (recv_wait > 1) recv_wait <= recv_wait - 1;
      else out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned rand_image(int unsigned pool);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, (1 << POINT_W) - 1);
    return $urandom_range(0, pool - 1);
  endfunction

  function automatic void queue_write(int unsigned g, int unsigned p, int unsigned img);
    poc_in_t req;
    req.action      = ACT_WRITE;
    req.generator   = GEN_W'(g);
    req.point       = POINT_W'(p);
    req.image_point = POINT_W'(img);
    request_q = {request_q, req};
    loaded[g][p] = 1'b1;
    items_sent++;
  endfunction

  function automatic void queue_compute();
    poc_in_t req;
    req.action      = ACT_COMPUTE;
    req.generator   = GEN_W'($urandom);
    req.point       = POINT_W'($urandom);
    req.image_point = POINT_W'($urandom);
    request_q = {request_q, req};
    items_sent++;
    computes_sent++;
  endfunction

  function automatic void queue_noise(int unsigned pool);
    int unsigned g;
    int unsigned p;
    int unsigned img;
    g = $urandom_range(0, POC_GEN_MAX - 1);
    if (pool != 0 && $urandom_range(0, 2) != 0) p = $urandom_range(0, pool - 1);
    else p = $urandom_range(0, POC_POOL_MAX - 1);
    img = (pool != 0) ? rand_image(pool) : $urandom_range(0, (1 << POINT_W) - 1);
    queue_write(g, p, img);
  endfunction

  // every entry a compute will read must be loaded first
  function automatic void fill_rect(int unsigned pool, int unsigned gens);
    for (int g = 0; g < gens; g++)
      for (int p = 0; p < pool; p++)
        if (!loaded[g][p]) queue_write(g, p, rand_image(pool));
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || in_if.valid || orbit_results_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_cfg(cfg_reg_e idx, int unsigned val);
    wait_drained();
    repeat (8) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POOL_LEN) cfg_pool = val & ((1 << POOL_LEN_W) - 1);
    else cfg_gens = val & ((1 << GEN_COUNT_W) - 1);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned pool_cfg;
    int unsigned gens_cfg;
    int unsigned eff_pool;
    int unsigned eff_gens;
    int unsigned pick;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_POOL_LEN;
    cfg_data_i   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one orbit of three with an out of range image
    set_cfg(CFG_POOL_LEN, 3);
    set_cfg(CFG_GEN_COUNT, 2);
    queue_write(0, 0, 1);
    queue_write(0, 1, 2);
    queue_write(0, 2, 0);
    queue_write(1, 0, 0);
    queue_write(1, 1, 1);
    queue_write(1, 2, 1023);
    queue_compute();
    // no generators, empty pool, full and oversized pool
    set_cfg(CFG_GEN_COUNT, 0);
    queue_compute();
    set_cfg(CFG_POOL_LEN, 0);
    queue_compute();
    set_cfg(CFG_POOL_LEN, POC_POOL_MAX);
    queue_compute();
    set_cfg(CFG_POOL_LEN, 2047);
    queue_compute();
    // single point, oversized generator count
    set_cfg(CFG_POOL_LEN, 1);
    set_cfg(CFG_GEN_COUNT, 15);
    for (int g = 2; g < POC_GEN_MAX; g++) queue_write(g, 0, (g == 7) ? 1023 : g % 2);
    queue_compute();
    queue_write(7, 1023, 1023);
    queue_write(7, 1023, 0);

    // whole pool under one generator
    set_cfg(CFG_POOL_LEN, POC_POOL_MAX);
    set_cfg(CFG_GEN_COUNT, 1);
    fill_rect(POC_POOL_MAX, 1);
    queue_compute();

    while (items_sent < ITEM_TARGET || computes_sent < COMPUTE_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        pool_cfg = $urandom_range(POC_POOL_MAX, (1 << POOL_LEN_W) - 1);
        gens_cfg = $urandom_range(0, 1);
      end else if (pick == 1) begin
        pool_cfg = 0;
        gens_cfg = $urandom_range(0, (1 << GEN_COUNT_W) - 1);
      end else if (pick <= 4) begin
        pool_cfg = $urandom_range(25, 64);
        gens_cfg = $urandom_range(0, 2);
      end else begin
        pool_cfg = $urandom_range(1, 24);
        gens_cfg = $urandom_range(0, (1 << GEN_COUNT_W) - 1);
      end
      set_cfg(CFG_POOL_LEN, pool_cfg);
      set_cfg(CFG_GEN_COUNT, gens_cfg);
      eff_pool = (pool_cfg > POC_POOL_MAX) ? POC_POOL_MAX : pool_cfg;
      eff_gens = (gens_cfg > POC_GEN_MAX) ? POC_GEN_MAX : gens_cfg;
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 12)) queue_noise(eff_pool);
        fill_rect(eff_pool, eff_gens);
        queue_compute();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
